FILE: hw/rtl/rdpc_pkg.sv
// Package for the row dark pixel centroid block: payload types, widths,
// constants and the command and status groups between controller and datapath.
// Depends on nothing.
`default_nettype none

package rdpc_pkg;

  // Field widths of the pixel stream and of the results.
  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int CNT_W   = 10;

  // Accumulator widths, sized for rows of up to 1024 pixels.
  localparam int WSUM_W  = 18;
  localparam int MSUM_W  = 27;
  localparam int NUM_W   = MSUM_W + 1;

  // The centroid quotient never exceeds the last column, so it has COL_W bits.
  localparam int DIV_STEPS  = COL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int                ROW_PIXELS_DEF = 640;
  localparam logic [PIX_W-1:0]  THRESH_RESET   = 8'd120;
  localparam logic [PIX_W-1:0]  WHITE          = 8'd255;
  localparam logic [CNT_W-1:0]  CNT_MAX        = 10'd1023;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] center_col;
    logic             found;
    logic [CNT_W-1:0] rows_found;
    logic             frame_done;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic capture;
    logic div_step;
    logic load_out;
  } rdpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_end;
    logic out_free;
  } rdpc_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rdpc_datapath.sv
// Datapath of the row dark pixel centroid block: threshold register, row
// accumulators, frame row count, shift-subtract divider and result register.
// Depends on rdpc_pkg.
`default_nettype none

module rdpc_datapath #(
  parameter int ROW_PIXELS = rdpc_pkg::ROW_PIXELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [7:0]            cfg_data,
  input  wire rdpc_pkg::pixel_t      pix,
  input  wire logic                  res_stall,
  input  wire rdpc_pkg::rdpc_cmd_t   cmd,
  output rdpc_pkg::rdpc_status_t     status,
  output logic                       res_valid,
  output rdpc_pkg::result_t          res
);
  import rdpc_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_PIXELS - 1);

  logic [PIX_W-1:0]  threshold;
  logic [COL_W-1:0]  column;
  logic              row_full;
  logic [WSUM_W-1:0] weight_sum;
  logic [MSUM_W-1:0] moment_sum;
  logic [CNT_W-1:0]  row_count;
  logic              frame_pend;

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dshift;
  logic [COL_W-1:0]  quot;
  logic              found_r;
  logic              frame_r;
  logic [CNT_W-1:0]  rows_r;

  logic [PIX_W-1:0]  weight;
  logic [MSUM_W-1:0] product;
  logic              row_found;
  logic [CNT_W-1:0]  count_next;

  // Weight of the incoming pixel and its moment contribution.
  always_comb begin
    weight  = (pix.pixel < threshold) ? (WHITE - pix.pixel) : '0;
    product = MSUM_W'(weight) * MSUM_W'(column);
  end

  // Found-row count including the row being closed, saturating.
  always_comb begin
    row_found  = (weight_sum != '0);
    count_next = (row_found && (row_count != CNT_MAX)) ? row_count + 1'b1 : row_count;
  end

  assign status.item_end = pix.row_end | pix.frame_end;
  assign status.out_free = !res_valid || !res_stall;

  // Threshold register: the user writes it only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wen) begin
      threshold <= cfg_data;
    end
  end

  // Row accumulation, then capture of the row into the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row_full   <= 1'b0;
      weight_sum <= '0;
      moment_sum <= '0;
      row_count  <= '0;
      frame_pend <= 1'b0;
    end else if (cmd.capture) begin
      column     <= '0;
      row_full   <= 1'b0;
      weight_sum <= '0;
      moment_sum <= '0;
      row_count  <= frame_pend ? '0 : count_next;
    end else if (cmd.accept) begin
      frame_pend <= pix.frame_end;
      if (!row_full) begin
        weight_sum <= weight_sum + WSUM_W'(weight);
        moment_sum <= moment_sum + product;
        if (column >= LAST_COL) begin
          row_full <= 1'b1;
        end else begin
          column <= column + 1'b1;
        end
      end
    end
  end

  // Restoring divider: floor((2*moment + sum) / (2*sum)), one quotient bit a step.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem     <= {moment_sum, 1'b0} + NUM_W'(weight_sum);
      dshift  <= NUM_W'({weight_sum, 1'b0}) << (DIV_STEPS - 1);
      quot    <= '0;
      found_r <= row_found;
      frame_r <= frame_pend;
      rows_r  <= count_next;
    end else if (cmd.div_step) begin
      dshift <= dshift >> 1;
      if (rem >= dshift) begin
        rem  <= rem - dshift;
        quot <= {quot[COL_W-2:0], 1'b1};
      end else begin
        quot <= {quot[COL_W-2:0], 1'b0};
      end
    end
  end

  // Result register; it holds its transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.center_col <= found_r ? quot : '0;
      res.found      <= found_r;
      res.rows_found <= frame_r ? rows_r : '0;
      res.frame_done <= frame_r;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rdpc_controller.sv
// Controller of the row dark pixel centroid block: sequences accumulation,
// capture, the divider steps and the hand-over to the result register.
// Depends on rdpc_pkg.
`default_nettype none

module rdpc_controller (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pix_valid,
  output logic                        pix_stall,
  input  wire rdpc_pkg::rdpc_status_t status,
  output rdpc_pkg::rdpc_cmd_t         cmd
);
  import rdpc_pkg::*;

  localparam logic [1:0] ST_ACCUM   = 2'd0;
  localparam logic [1:0] ST_CAPTURE = 2'd1;
  localparam logic [1:0] ST_DIVIDE  = 2'd2;
  localparam logic [1:0] ST_OUTPUT  = 2'd3;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;

  assign pix_stall = (state != ST_ACCUM);

  // Commands for the datapath.
  always_comb begin
    cmd.accept   = pix_valid && !pix_stall;
    cmd.capture  = (state == ST_CAPTURE);
    cmd.div_step = (state == ST_DIVIDE);
    cmd.load_out = (state == ST_OUTPUT) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        if (cmd.accept && status.item_end) state_next = ST_CAPTURE;
      end
      ST_CAPTURE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (step == LAST_STEP) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (status.out_free) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIVIDE) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/row_dark_pixel_centroid.sv
// Top level of the row dark pixel centroid block: joins the controller and
// the datapath. Depends on rdpc_pkg, rdpc_controller and rdpc_datapath.
//
// Usage:
//   Pixels arrive in raster order on pix (pix_valid / pix_stall); a
//   transaction is taken when pix_valid is high and pix_stall low.
//   A pixel that ends no row is taken every cycle and gives no result.
//   A pixel that ends a row (row_end or frame_end) gives one result on res
//   (res_valid / res_stall): res_valid rises after that pixel is taken and
//   the block has passed the capture state, ten shift-subtract steps of the
//   divider and the load of the result register. The input is stalled from
//   that pixel until the result is loaded, so no new pixel is taken meanwhile.
//   If the receiver stalls, the result is held; a further row end still
//   runs the divider and then waits, input stalled, until the register frees.
//   The threshold is written through cfg_wen / cfg_data only while idle, which the
//   user must keep to; the block does not enforce it. Reset clears the row sums,
//   the frame row count and the handshakes, and sets the threshold to 120.
`default_nettype none

module row_dark_pixel_centroid #(
  parameter int ROW_PIXELS = rdpc_pkg::ROW_PIXELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              pix_valid,
  output logic                   pix_stall,
  input  wire rdpc_pkg::pixel_t  pix,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output rdpc_pkg::result_t      res
);
  import rdpc_pkg::*;

  rdpc_cmd_t    cmd;
  rdpc_status_t status;

  rdpc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rdpc_datapath #(
    .ROW_PIXELS (ROW_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .res_stall (res_stall),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rdpc_checker.sv
// Port checker for the row dark pixel centroid block, bound to the top level.
// Depends on rdpc_pkg and row_dark_pixel_centroid.
`default_nettype none

module rdpc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pix_valid,
  input wire logic              pix_stall,
  input wire rdpc_pkg::pixel_t  pix,
  input wire logic              res_valid,
  input wire logic              res_stall,
  input wire rdpc_pkg::result_t res
);

  // A stalled result transaction stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // A row without dark pixels reports column zero.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.found |-> res.center_col == '0)
    else $error("center_col nonzero for a row without dark pixels");

  // The row count is reported only with the frame's last row.
  a_count_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.frame_done |-> res.rows_found == '0)
    else $error("rows_found nonzero outside frame end");

  // A found last row is itself counted.
  a_count_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.found && res.frame_done |-> res.rows_found != '0)
    else $error("found last row missing from rows_found");

  // A row-ending pixel is followed by a stall of the input.
  a_end_stall: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall && (pix.row_end || pix.frame_end) |=> pix_stall)
    else $error("input not stalled after a row end");

endmodule

bind row_dark_pixel_centroid rdpc_checker u_rdpc_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .pix       (pix),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire
